/* design/tsel_pkg.sv */
`timescale 1ns / 1ps

package tsel_pkg;

   // default sizes
   localparam int EVENT_DEPTH_DEF  = 16;
   localparam int WAITER_DEPTH_DEF = 8;
   localparam int STAMP_BITS_DEF   = 32;

   // fixed field widths on the ports
   localparam int STAMP_PORT_W = 32;
   localparam int ID_W         = 8;
   localparam int MODE_W       = 2;
   localparam int KIND_W       = 3;
   localparam int TDATA_W      = 48;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INSERT     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY_WAIT = 2'd2;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT  = 3'd0,
      KIND_HIT     = 3'd1,
      KIND_MISS    = 3'd2,
      KIND_RELEASE = 3'd3,
      KIND_FULL    = 3'd4
   } kind_type;

   // event ring commands
   typedef struct packed {
      logic append;
      logic walk_start;
      logic walk_read;
   } ev_cmd_type;

   // waiter table commands
   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } wt_cmd_type;

endpackage

/* design/tsel_event_log.sv */
`timescale 1ns / 1ps

module tsel_event_log #(
   parameter int EVENT_DEPTH = tsel_pkg::EVENT_DEPTH_DEF,
   parameter int STAMP_W     = tsel_pkg::STAMP_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tsel_pkg::ev_cmd_type ev_cmd,
   input  logic [STAMP_W-1:0]   wr_stamp,
   input  logic                 wr_edge,
   output logic                 walk_end,
   output logic [STAMP_W-1:0]   rd_stamp,
   output logic                 rd_edge
);

   localparam int IW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
   localparam int CW = $clog2(EVENT_DEPTH + 1);

   logic [IW-1:0]  oldest_ff, oldest_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [IW-1:0]  walk_ptr_ff, walk_ptr_in;
   logic [CW-1:0]  walk_left_ff, walk_left_in;
   logic [STAMP_W:0] rd_word_ff;
   logic [STAMP_W:0] ev_mem [EVENT_DEPTH];

   logic           full;
   logic [IW:0]    tail_sum;
   logic [IW-1:0]  slot;
   logic [IW-1:0]  oldest_next;
   logic [IW-1:0]  walk_next;

   // tail slot of the ring, wrapping at the depth
   always_comb begin
      full        = (count_ff == CW'(EVENT_DEPTH));
      tail_sum    = {1'b0, oldest_ff} + (IW+1)'(count_ff);
      oldest_next = (oldest_ff == IW'(EVENT_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
      walk_next   = (walk_ptr_ff == IW'(EVENT_DEPTH - 1)) ? '0 : walk_ptr_ff + 1'b1;
      if (full) begin
         slot = oldest_ff;
      end else if (tail_sum >= (IW+1)'(EVENT_DEPTH)) begin
         slot = IW'(tail_sum - (IW+1)'(EVENT_DEPTH));
      end else begin
         slot = tail_sum[IW-1:0];
      end
   end

   // pointer and count updates
   always_comb begin
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      walk_ptr_in  = walk_ptr_ff;
      walk_left_in = walk_left_ff;
      if (ev_cmd.append) begin
         if (full) begin
            oldest_in = oldest_next;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (ev_cmd.walk_start) begin
         walk_ptr_in  = oldest_ff;
         walk_left_in = count_ff;
      end else if (ev_cmd.walk_read) begin
         walk_ptr_in  = walk_next;
         walk_left_in = walk_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         count_ff     <= '0;
         walk_ptr_ff  <= '0;
         walk_left_ff <= '0;
      end else begin
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         walk_ptr_ff  <= walk_ptr_in;
         walk_left_ff <= walk_left_in;
      end
   end

   // event store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (ev_cmd.append) begin
         ev_mem[slot] <= {wr_stamp, wr_edge};
      end
      if (ev_cmd.walk_read) begin
         rd_word_ff <= ev_mem[walk_ptr_ff];
      end
   end

   assign walk_end = (walk_left_ff == '0);
   assign rd_stamp = rd_word_ff[STAMP_W:1];
   assign rd_edge  = rd_word_ff[0];

endmodule

/* design/tsel_waiter_table.sv */
`timescale 1ns / 1ps

module tsel_waiter_table #(
   parameter int WAITER_DEPTH = tsel_pkg::WAITER_DEPTH_DEF,
   parameter int STAMP_W      = tsel_pkg::STAMP_BITS_DEF,
   parameter int WW           = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tsel_pkg::wt_cmd_type      wt_cmd,
   input  logic [WW-1:0]             idx,
   input  logic [STAMP_W-1:0]        wr_stamp,
   input  logic [tsel_pkg::ID_W-1:0] wr_ident,
   output logic                      slot_valid,
   output logic [STAMP_W-1:0]        rd_stamp,
   output logic [tsel_pkg::ID_W-1:0] rd_ident
);

   logic [WAITER_DEPTH-1:0] valid_ff, valid_in;
   logic [STAMP_W+tsel_pkg::ID_W-1:0] rd_word_ff;
   logic [STAMP_W+tsel_pkg::ID_W-1:0] wt_mem [WAITER_DEPTH];

   // slot occupancy flags
   always_comb begin
      valid_in = valid_ff;
      if (wt_cmd.wr) begin
         valid_in[idx] = 1'b1;
      end else if (wt_cmd.clr) begin
         valid_in[idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // waiter stamp and identifier store
   always_ff @(posedge clock) begin
      if (wt_cmd.wr) begin
         wt_mem[idx] <= {wr_stamp, wr_ident};
      end
      if (wt_cmd.rd) begin
         rd_word_ff <= wt_mem[idx];
      end
   end

   assign slot_valid = valid_ff[idx];
   assign rd_stamp   = rd_word_ff[STAMP_W+tsel_pkg::ID_W-1:tsel_pkg::ID_W];
   assign rd_ident   = rd_word_ff[tsel_pkg::ID_W-1:0];

endmodule

/* design/tsel_seq.sv */
`timescale 1ns / 1ps

module tsel_seq #(
   parameter int WAITER_DEPTH = tsel_pkg::WAITER_DEPTH_DEF,
   parameter int STAMP_W      = tsel_pkg::STAMP_BITS_DEF,
   parameter int WW           = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   // request word
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tsel_pkg::MODE_W-1:0]       req_mode,
   input  logic [STAMP_W-1:0]                req_stamp,
   input  logic [tsel_pkg::ID_W-1:0]         req_ident,
   // event ring
   output tsel_pkg::ev_cmd_type              ev_cmd,
   input  logic                              ev_walk_end,
   input  logic [STAMP_W-1:0]                ev_rd_stamp,
   input  logic                              ev_rd_edge,
   // waiter table
   output tsel_pkg::wt_cmd_type              wt_cmd,
   output logic [WW-1:0]                     wt_idx,
   output logic [STAMP_W-1:0]                wt_wr_stamp,
   output logic [tsel_pkg::ID_W-1:0]         wt_wr_ident,
   input  logic                              wt_slot_valid,
   input  logic [STAMP_W-1:0]                wt_rd_stamp,
   input  logic [tsel_pkg::ID_W-1:0]         wt_rd_ident,
   // response word
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tsel_pkg::kind_type                rsp_kind,
   output logic [tsel_pkg::STAMP_PORT_W-1:0] rsp_stamp,
   output logic                              rsp_edge,
   output logic [tsel_pkg::ID_W-1:0]         rsp_ident,
   output logic                              rsp_last
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_WRD   = 7'b0000010,
      S_WCMP  = 7'b0000100,
      S_QRD   = 7'b0001000,
      S_QCMP  = 7'b0010000,
      S_FREE  = 7'b0100000,
      S_FLUSH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [WW-1:0]               idx_ff, idx_in;
   logic [tsel_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [STAMP_W-1:0]          stamp_ff, stamp_in;
   logic [tsel_pkg::ID_W-1:0]   ident_ff, ident_in;

   // result held back until it is known whether another follows
   tsel_pkg::kind_type          pend_kind_ff, pend_kind_in;
   logic [STAMP_W-1:0]          pend_stamp_ff, pend_stamp_in;
   logic                        pend_edge_ff, pend_edge_in;
   logic [tsel_pkg::ID_W-1:0]   pend_ident_ff, pend_ident_in;

   // output register
   logic                              out_valid_ff, out_valid_in;
   tsel_pkg::kind_type                out_kind_ff, out_kind_in;
   logic [tsel_pkg::STAMP_PORT_W-1:0] out_stamp_ff, out_stamp_in;
   logic                              out_edge_ff, out_edge_in;
   logic [tsel_pkg::ID_W-1:0]         out_ident_ff, out_ident_in;
   logic                              out_last_ff, out_last_in;

   logic accept;
   logic out_free;
   logic out_load;
   logic out_last;
   logic idx_end;
   logic release_hit;

   assign accept      = req_valid && req_ready;
   assign out_free    = !out_valid_ff || rsp_ready;
   assign idx_end     = (idx_ff == WW'(WAITER_DEPTH - 1));
   assign release_hit = wt_slot_valid && (wt_rd_stamp < stamp_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      mode_in       = mode_ff;
      stamp_in      = stamp_ff;
      ident_in      = ident_ff;
      pend_kind_in  = pend_kind_ff;
      pend_stamp_in = pend_stamp_ff;
      pend_edge_in  = pend_edge_ff;
      pend_ident_in = pend_ident_ff;
      ev_cmd        = '0;
      wt_cmd        = '0;
      out_load      = 1'b0;
      out_last      = 1'b0;
      req_ready     = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in       = req_mode;
               stamp_in      = req_stamp;
               ident_in      = req_ident;
               idx_in        = '0;
               pend_stamp_in = '0;
               pend_edge_in  = 1'b0;
               pend_ident_in = '0;
               if (req_mode == tsel_pkg::MODE_INSERT) begin
                  ev_cmd.append = 1'b1;
                  pend_kind_in  = tsel_pkg::KIND_INSERT;
                  state_in      = S_WRD;
               end else if (req_mode == tsel_pkg::MODE_QUERY ||
                            req_mode == tsel_pkg::MODE_QUERY_WAIT) begin
                  ev_cmd.walk_start = 1'b1;
                  state_in          = S_QRD;
               end else begin
                  pend_kind_in = tsel_pkg::KIND_MISS;
                  state_in     = S_FLUSH;
               end
            end
         end
         S_WRD: begin
            wt_cmd.rd = 1'b1;
            state_in  = S_WCMP;
         end
         S_WCMP: begin
            if (!release_hit || out_free) begin
               if (release_hit) begin
                  out_load      = 1'b1;
                  wt_cmd.clr    = 1'b1;
                  pend_kind_in  = tsel_pkg::KIND_RELEASE;
                  pend_stamp_in = stamp_ff;
                  pend_edge_in  = 1'b0;
                  pend_ident_in = wt_rd_ident;
               end
               if (idx_end) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_WRD;
               end
            end
         end
         S_QRD: begin
            if (ev_walk_end) begin
               if (mode_ff == tsel_pkg::MODE_QUERY_WAIT) begin
                  state_in = S_FREE;
               end else begin
                  pend_kind_in = tsel_pkg::KIND_MISS;
                  state_in     = S_FLUSH;
               end
            end else begin
               ev_cmd.walk_read = 1'b1;
               state_in         = S_QCMP;
            end
         end
         S_QCMP: begin
            if (ev_rd_stamp > stamp_ff) begin
               pend_kind_in  = tsel_pkg::KIND_HIT;
               pend_stamp_in = ev_rd_stamp;
               pend_edge_in  = ev_rd_edge;
               state_in      = S_FLUSH;
            end else begin
               state_in = S_QRD;
            end
         end
         S_FREE: begin
            if (!wt_slot_valid) begin
               wt_cmd.wr    = 1'b1;
               pend_kind_in = tsel_pkg::KIND_MISS;
               state_in     = S_FLUSH;
            end else if (idx_end) begin
               pend_kind_in = tsel_pkg::KIND_FULL;
               state_in     = S_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register load and hand-off
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_stamp_in = out_stamp_ff;
      out_edge_in  = out_edge_ff;
      out_ident_in = out_ident_ff;
      out_last_in  = out_last_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_kind_in  = pend_kind_ff;
         out_stamp_in = tsel_pkg::STAMP_PORT_W'(pend_stamp_ff);
         out_edge_in  = pend_edge_ff;
         out_ident_in = pend_ident_ff;
         out_last_in  = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      mode_ff       <= mode_in;
      stamp_ff      <= stamp_in;
      ident_ff      <= ident_in;
      pend_kind_ff  <= pend_kind_in;
      pend_stamp_ff <= pend_stamp_in;
      pend_edge_ff  <= pend_edge_in;
      pend_ident_ff <= pend_ident_in;
      out_kind_ff   <= out_kind_in;
      out_stamp_ff  <= out_stamp_in;
      out_edge_ff   <= out_edge_in;
      out_ident_ff  <= out_ident_in;
      out_last_ff   <= out_last_in;
   end

   assign wt_idx      = idx_ff;
   assign wt_wr_stamp = stamp_ff;
   assign wt_wr_ident = ident_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_kind    = out_kind_ff;
   assign rsp_stamp   = out_stamp_ff;
   assign rsp_edge    = out_edge_ff;
   assign rsp_ident   = out_ident_ff;
   assign rsp_last    = out_last_ff;

endmodule

/* design/timestamped_edge_event_log.sv */
`timescale 1ns / 1ps
// insert: each waiter slot is read in S_WRD and compared in S_WCMP, in turn from the first
// query: each stored event is read in S_QRD and compared in S_QCMP, walked from the oldest,
// plus a search for a free waiter slot on a registering miss; one item at a time
// a finished word waits in the output register while the next item is taken
// reset clears the ring pointers, the event count and the waiter valid flags;
// the event and waiter stores are not cleared and there is no clearing pass

module timestamped_edge_event_log #(
   parameter int EVENT_DEPTH  = tsel_pkg::EVENT_DEPTH_DEF,
   parameter int WAITER_DEPTH = tsel_pkg::WAITER_DEPTH_DEF,
   parameter int STAMP_BITS   = tsel_pkg::STAMP_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // stamp[31:0], edge_req[32], waiter_id[40:33], zero fill[47:41]
   input  logic [tsel_pkg::TDATA_W-1:0]   req_tdata,
   // mode[1:0]
   input  logic [tsel_pkg::MODE_W-1:0]    req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // found_stamp[31:0], found_edge[32], released_id[40:33], zero fill[47:41]
   output logic [tsel_pkg::TDATA_W-1:0]   rsp_tdata,
   // kind[2:0]
   output logic [tsel_pkg::KIND_W-1:0]    rsp_tuser,
   output logic                           rsp_tlast
);

   localparam int STAMP_W = (STAMP_BITS < tsel_pkg::STAMP_PORT_W) ?
                            STAMP_BITS : tsel_pkg::STAMP_PORT_W;
   localparam int WW      = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
   localparam int PAD_W   = tsel_pkg::TDATA_W - tsel_pkg::STAMP_PORT_W - 1 - tsel_pkg::ID_W;

   tsel_pkg::ev_cmd_type              ev_cmd;
   logic                              ev_walk_end;
   logic [STAMP_W-1:0]                ev_rd_stamp;
   logic                              ev_rd_edge;
   tsel_pkg::wt_cmd_type              wt_cmd;
   logic [WW-1:0]                     wt_idx;
   logic [STAMP_W-1:0]                wt_wr_stamp;
   logic [tsel_pkg::ID_W-1:0]         wt_wr_ident;
   logic                              wt_slot_valid;
   logic [STAMP_W-1:0]                wt_rd_stamp;
   logic [tsel_pkg::ID_W-1:0]         wt_rd_ident;
   tsel_pkg::kind_type                rsp_kind;
   logic [tsel_pkg::STAMP_PORT_W-1:0] rsp_stamp;
   logic                              rsp_edge;
   logic [tsel_pkg::ID_W-1:0]         rsp_ident;
   logic [STAMP_W-1:0]                req_stamp;

   // only the low stamp bits take part
   assign req_stamp = req_tdata[STAMP_W-1:0];

   tsel_event_log #(
      .EVENT_DEPTH (EVENT_DEPTH),
      .STAMP_W     (STAMP_W)
   ) u_event_log (
      .clock    (clock),
      .reset    (reset),
      .ev_cmd   (ev_cmd),
      .wr_stamp (req_stamp),
      .wr_edge  (req_tdata[tsel_pkg::STAMP_PORT_W]),
      .walk_end (ev_walk_end),
      .rd_stamp (ev_rd_stamp),
      .rd_edge  (ev_rd_edge)
   );

   tsel_waiter_table #(
      .WAITER_DEPTH (WAITER_DEPTH),
      .STAMP_W      (STAMP_W),
      .WW           (WW)
   ) u_waiter_table (
      .clock      (clock),
      .reset      (reset),
      .wt_cmd     (wt_cmd),
      .idx        (wt_idx),
      .wr_stamp   (wt_wr_stamp),
      .wr_ident   (wt_wr_ident),
      .slot_valid (wt_slot_valid),
      .rd_stamp   (wt_rd_stamp),
      .rd_ident   (wt_rd_ident)
   );

   tsel_seq #(
      .WAITER_DEPTH (WAITER_DEPTH),
      .STAMP_W      (STAMP_W),
      .WW           (WW)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_mode      (req_tuser),
      .req_stamp     (req_stamp),
      .req_ident     (req_tdata[tsel_pkg::STAMP_PORT_W+tsel_pkg::ID_W:tsel_pkg::STAMP_PORT_W+1]),
      .ev_cmd        (ev_cmd),
      .ev_walk_end   (ev_walk_end),
      .ev_rd_stamp   (ev_rd_stamp),
      .ev_rd_edge    (ev_rd_edge),
      .wt_cmd        (wt_cmd),
      .wt_idx        (wt_idx),
      .wt_wr_stamp   (wt_wr_stamp),
      .wt_wr_ident   (wt_wr_ident),
      .wt_slot_valid (wt_slot_valid),
      .wt_rd_stamp   (wt_rd_stamp),
      .wt_rd_ident   (wt_rd_ident),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_kind      (rsp_kind),
      .rsp_stamp     (rsp_stamp),
      .rsp_edge      (rsp_edge),
      .rsp_ident     (rsp_ident),
      .rsp_last      (rsp_tlast)
   );

   // response word packing
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_ident, rsp_edge, rsp_stamp};
   assign rsp_tuser = rsp_kind;

   // one item at a time: the word after an accepted one is never taken at once
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on consecutive cycles");

   // only insert done and releases can be followed by another word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tuser == tsel_pkg::KIND_INSERT || rsp_tuser == tsel_pkg::KIND_RELEASE)
      else $error("non-final word of unexpected kind");

   // edge flag only on hits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != tsel_pkg::KIND_HIT |-> !rsp_tdata[tsel_pkg::STAMP_PORT_W])
      else $error("edge flag set outside a hit");

   // released identifier only on releases
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != tsel_pkg::KIND_RELEASE |->
         rsp_tdata[tsel_pkg::STAMP_PORT_W+tsel_pkg::ID_W:tsel_pkg::STAMP_PORT_W+1] == '0)
      else $error("identifier set outside a release");

endmodule
